>>> rtl/pist_pkg.sv
// ----------------------------------------------------------------------------
// pist_pkg: shared types and codes for the protected id set table
// Operation and status codes, field widths and the command struct that the
// top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package pist_pkg;

	localparam int unsigned ID_W  = 32;
	localparam int unsigned OP_W  = 2;
	localparam int unsigned ST_W  = 2;
	localparam int unsigned OUT_CNT_W = 7;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP       = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	// command seen by all cells in the update cycle
	typedef struct packed {
		logic            ins_en;  // store pid in the cell whose slot equals the count
		logic            rem_en;  // close the gap at the matching cell
		logic [ID_W-1:0] pid;
	} pist_cmd_t;

endpackage

>>> rtl/pist_cell.sv
// ----------------------------------------------------------------------------
// pist_cell: one slot of the identifier chain
// Holds one identifier and its valid mark, reports a match, and on a remove
// takes over the contents of its upper neighbor when the hole is at or below.
// ----------------------------------------------------------------------------
module pist_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pist_pkg::pist_cmd_t      cmd,
	input  logic                     wr_here,    // this slot is the next free one
	input  logic                     shift_in,   // a match lies below this cell
	input  logic [pist_pkg::ID_W-1:0] up_id,
	input  logic                     up_valid,
	output logic                     hit,
	output logic                     shift_out,
	output logic [pist_pkg::ID_W-1:0] id_q,
	output logic                     valid_q
);
	import pist_pkg::*;

	assign hit       = valid_q && (id_q == cmd.pid);
	assign shift_out = shift_in | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem_en && shift_out) begin
			valid_q <= up_valid;
		end else if (cmd.ins_en && wr_here) begin
			valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.rem_en && shift_out) begin
			id_q <= up_id;
		end else if (cmd.ins_en && wr_here) begin
			id_q <= cmd.pid;
		end
	end

endmodule

>>> rtl/protected_id_set_table.sv
// ----------------------------------------------------------------------------
// protected_id_set_table: bounded set of 32-bit identifiers
// Lookup, insert and remove on a packed chain of SET_SIZE identifier cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave side (s_*): one beat per operation. s_tuser carries the operation
//    (lookup, insert, remove; the unused code behaves as a lookup), s_tdata
//    carries the identifier.
//  - Master side (m_*): one beat per operation with status, the membership
//    flag (presence before the operation) and the entry count after it.
//  - In the accept cycle a beat's operation is registered; in its update
//    cycle, once the output register is free, the identifier is compared
//    against every cell at once, the chain is updated and the output register
//    loaded, which raises m_tvalid. A new beat is accepted only after the
//    previous one's single compare-and-update cycle over the whole chain.
//  - Entries stay packed in slots 0..count-1: an insert writes slot count, a
//    remove makes every cell at and above the match take its upper
//    neighbor's contents in the same cycle.
//  - Reset clears all valid marks and the count; no clearing pass is needed.
//  - While a result waits on a stalled m_tready, the next beat is still
//    accepted; its update then waits until the output register is free.
// ----------------------------------------------------------------------------
module protected_id_set_table #(
	parameter int unsigned SET_SIZE = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] process_id
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] status, [2] member, [9:3] entry_count, [15:10] 0
);
	import pist_pkg::*;

	localparam int unsigned CNT_W = $clog2(SET_SIZE + 1);

	// accepted beat, waiting for its update cycle
	logic              busy_q;
	logic [OP_W-1:0]   op_s1;
	logic [ID_W-1:0]   pid_s1;

	logic [CNT_W-1:0]  count_q;

	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	// chain wiring
	logic [SET_SIZE-1:0] hit;
	logic [SET_SIZE:0]   shift;
	logic [ID_W-1:0]     cell_id    [SET_SIZE];
	logic [SET_SIZE-1:0] cell_valid;

	logic       exec;
	logic       present;
	logic       is_full;
	pist_cmd_t  cmd;
	logic [ST_W-1:0]  status;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W+OUT_CNT_W-1:0] count_ext;

	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// update cycle fires once the output register can take the result
	assign exec    = busy_q && (!m_tvalid_q || m_tready);
	assign present = |hit;
	assign is_full = (count_q >= CNT_W'(SET_SIZE));

	always_comb begin
		cmd.pid    = pid_s1;
		cmd.ins_en = exec && (op_s1 == OP_INSERT) && !is_full && !present;
		cmd.rem_en = exec && (op_s1 == OP_REMOVE) && present;

		status    = ST_OK;
		count_nxt = count_q;
		case (op_s1)
			OP_INSERT: begin
				if (is_full) begin
					status = ST_FULL;
				end else if (present) begin
					status = ST_DUP;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (present) begin
					count_nxt = count_q - CNT_W'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			default: begin
				status = ST_OK;   // lookup and unused code
			end
		endcase
		count_ext = {{OUT_CNT_W{1'b0}}, count_nxt};
	end

	// the chain of cells; the top cell pulls in an empty slot on a remove
	assign shift[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < SET_SIZE; gi++) begin : g_cell
			logic [ID_W-1:0] up_id;
			logic            up_valid;
			if (gi == SET_SIZE - 1) begin : g_top
				assign up_id    = '0;
				assign up_valid = 1'b0;
			end else begin : g_mid
				assign up_id    = cell_id[gi+1];
				assign up_valid = cell_valid[gi+1];
			end

			pist_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.wr_here   (count_q == CNT_W'(gi)),
				.shift_in  (shift[gi]),
				.up_id     (up_id),
				.up_valid  (up_valid),
				.hit       (hit[gi]),
				.shift_out (shift[gi+1]),
				.id_q      (cell_id[gi]),
				.valid_q   (cell_valid[gi])
			);
		end
	endgenerate

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end

			if (exec) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			pid_s1 <= s_tdata;
		end
		if (exec) begin
			m_tdata_q <= {6'b0, count_ext[OUT_CNT_W-1:0], present, status};
		end
	end

endmodule
